// ----- src/fsd_pkg.sv -----
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared constants and arithmetic helpers for the error-diffusion dither.
// ----------------------------------------------------------------------------
`default_nettype none

package fsd_pkg;

  localparam int MAX_WIDTH_DEF = 4096;

  localparam int ACC_W      = 12;
  localparam int GRAY_W     = 8;
  localparam int WIDTH_W    = 13;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic signed [ACC_W-1:0] ACC_MAX    = 12'sd2047;
  localparam logic signed [ACC_W-1:0] ACC_MIN    = -12'sd2048;
  localparam logic signed [ACC_W-1:0] THRESHOLD  = 12'sd127;
  localparam logic signed [ACC_W:0]   FULL_SCALE = 13'sd255;

  localparam logic [2:0] W_RIGHT = 3'd7;
  localparam logic [2:0] W_BL    = 3'd3;
  localparam logic [2:0] W_BELOW = 3'd5;
  localparam logic [2:0] W_BR    = 3'd1;

  typedef logic signed [ACC_W-1:0] acc_t;

  // clamp a 14-bit sum to the 12-bit accumulator range
  function automatic acc_t sat12(input logic signed [13:0] v);
    acc_t r;
    if (v > 14'sd2047) begin
      r = ACC_MAX;
    end else if (v < -14'sd2048) begin
      r = ACC_MIN;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  // (e * k) / 16, truncated toward zero
  function automatic acc_t share(input logic signed [12:0] e, input logic [2:0] k);
    logic signed [15:0] p;
    logic signed [15:0] q;
    p = $signed({{3{e[12]}}, e}) * $signed({13'b0, k});
    if (p[15]) begin
      q = (p + 16'sd15) >>> 4;
    end else begin
      q = p >>> 4;
    end
    return q[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/floyd_steinberg_dither.sv -----
// ----------------------------------------------------------------------------
// floyd_steinberg_dither
// Floyd-Steinberg error-diffusion dither, 8-bit gray in, one bit per pixel out.
// ----------------------------------------------------------------------------
// Usage: gray pixels enter in raster order on the in channel (valid/ready);
// each one gives one transfer on the out channel carrying pixel_on and
// last_in_frame, which flags the final pixel of the frame.
// Frame size is set through the cfg channel (index 0 width, 1 height); a
// write to either register restarts the frame. Write only while no pixel is in flight.
// A pixel passes through the work stage and then the output register on its
// way to the out channel. Throughput: one pixel per cycle while the receiver
// does not stall, set by the error update loop and the one read / one write
// port of the line store.
// A pixel sits in the work stage while the line store read is in flight; the
// next pixel is taken in the same cycle the current one moves to the output
// register. When the receiver stalls, the output register holds, the work
// stage fills, and in_ready_o drops until the output transfer happens.
// Reset: width 640, height 480, position and carries cleared. The line store
// needs no clearing pass: the first row of every frame reads zero error,
// and every later row only reads entries written by the row above.
// ----------------------------------------------------------------------------
`default_nettype none

module floyd_steinberg_dither #(
  parameter int MAX_WIDTH = fsd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [fsd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [fsd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [fsd_pkg::GRAY_W-1:0]       gray_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  pixel_on_o,
  output logic                                  last_in_frame_o
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > fsd_pkg::WIDTH_W) ? CW + 1 : fsd_pkg::WIDTH_W;
  localparam logic [WW-1:0] MaxW = WW'(MAX_WIDTH);

  // configuration
  logic [fsd_pkg::WIDTH_W-1:0]  width_q;
  logic [fsd_pkg::HEIGHT_W-1:0] height_q;
  logic                         cfg_fire;
  logic                         cfg_hit;

  // frame geometry
  logic [WW-1:0]                w_ext;
  logic [WW-1:0]                w_eff;
  logic [CW-1:0]                w_m1;
  logic [fsd_pkg::HEIGHT_W-1:0] h_m1;

  // handshake
  logic in_fire;
  logic fire;
  logic s1_valid_q;
  logic out_valid_q;
  logic [fsd_pkg::GRAY_W-1:0] gray_q;

  // position and carries
  logic [CW-1:0]                col_q, col_d;
  logic [fsd_pkg::HEIGHT_W-1:0] row_q, row_d;
  fsd_pkg::acc_t right_q, right_d;
  fsd_pkg::acc_t pend_q, pend_d;
  fsd_pkg::acc_t hold_q, hold_d;
  fsd_pkg::acc_t last_q, last_d;

  // line store
  fsd_pkg::acc_t mem [MAX_WIDTH];
  fsd_pkg::acc_t rd_q;
  fsd_pkg::acc_t byp_data_q;
  logic          byp_hit_q;
  logic          mem_we;
  logic [CW-1:0] waddr;
  fsd_pkg::acc_t wdata;

  // datapath
  logic               last_col, last_row;
  fsd_pkg::acc_t      below_err;
  logic signed [13:0] sum;
  fsd_pkg::acc_t      v;
  logic               on;
  logic signed [12:0] err;
  fsd_pkg::acc_t      s7, s3, s5, s1;
  fsd_pkg::acc_t      hold_new;

  logic pixel_on_q, last_frame_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_index_i)
      fsd_pkg::REG_IMAGE_WIDTH:  cfg_hit = 1'b1;
      fsd_pkg::REG_IMAGE_HEIGHT: cfg_hit = 1'b1;
      default:                   cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    w_ext = WW'(width_q);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = w_ext;
    end
    w_m1 = CW'(w_eff - WW'(1));
    h_m1 = (height_q == '0) ? '0 : height_q - fsd_pkg::HEIGHT_W'(1);
  end

  assign fire       = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | fire;
  assign in_fire    = in_valid_i & in_ready_o;

  assign last_col = (col_q == w_m1);
  assign last_row = (row_q == h_m1);

  always_comb begin
    if (row_q == '0) begin
      below_err = '0;
    end else if (last_col) begin
      below_err = last_q;
    end else if (byp_hit_q) begin
      below_err = byp_data_q;
    end else begin
      below_err = rd_q;
    end
    sum = $signed({6'b0, gray_q}) + 14'(below_err) + 14'(right_q);
    v   = fsd_pkg::sat12(sum);
    on  = (v >= fsd_pkg::THRESHOLD);
    err = 13'(v) - (on ? fsd_pkg::FULL_SCALE : 13'sd0);
    s7  = fsd_pkg::share(err, fsd_pkg::W_RIGHT);
    s3  = fsd_pkg::share(err, fsd_pkg::W_BL);
    s5  = fsd_pkg::share(err, fsd_pkg::W_BELOW);
    s1  = fsd_pkg::share(err, fsd_pkg::W_BR);
    hold_new = fsd_pkg::sat12(14'(pend_q) + 14'(s5));
    wdata    = fsd_pkg::sat12(14'(hold_q) + 14'(s3));
    waddr    = col_q - CW'(1);
    mem_we   = fire & ~last_row & (col_q != '0);
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    right_d = right_q;
    pend_d  = pend_q;
    hold_d  = hold_q;
    last_d  = last_q;
    if (cfg_fire && cfg_hit) begin
      col_d   = '0;
      row_d   = '0;
      right_d = '0;
      pend_d  = '0;
      hold_d  = '0;
      last_d  = '0;
    end else if (fire) begin
      right_d = last_col ? '0 : s7;
      if (!last_row) begin
        pend_d = last_col ? '0 : s1;
        if (last_col) begin
          last_d = hold_new;
          hold_d = '0;
        end else begin
          hold_d = hold_new;
        end
      end
      if (last_col && last_row) begin
        col_d   = '0;
        row_d   = '0;
        right_d = '0;
        pend_d  = '0;
        hold_d  = '0;
        last_d  = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = row_q + fsd_pkg::HEIGHT_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= fsd_pkg::WIDTH_RST;
      height_q    <= fsd_pkg::HEIGHT_RST;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      right_q     <= '0;
      pend_q      <= '0;
      hold_q      <= '0;
      last_q      <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index_i)
          fsd_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[fsd_pkg::WIDTH_W-1:0];
          fsd_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i[fsd_pkg::HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      col_q   <= col_d;
      row_q   <= row_d;
      right_q <= right_d;
      pend_q  <= pend_d;
      hold_q  <= hold_d;
      last_q  <= last_d;
    end
  end

  // line store with same-edge write bypass
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (in_fire) begin
      rd_q       <= mem[col_d];
      byp_hit_q  <= mem_we && (waddr == col_d);
      byp_data_q <= wdata;
      gray_q     <= gray_i;
    end
    if (fire) begin
      pixel_on_q   <= on;
      last_frame_q <= last_col & last_row;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_on_o      = pixel_on_q;
  assign last_in_frame_o = last_frame_q;

  // end of frame returns the position to the origin
  a_frame_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last_col && last_row) |=> (col_q == '0 && row_q == '0))
    else $error("position not cleared after last pixel");

  // column never runs past the row end
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_m1)
    else $error("column beyond row end");

  // input only stalls when both stages are full and the output is blocked
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without backpressure");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the error-diffusion dither. Gray pixels are sent
// in bursts with random gaps while the output side stalls on its own
// pattern; a line-store predictor computes each dithered pixel and the end
// of frame flag, and every output transfer is compared with the oldest
// prediction. Frame sizes are changed between phases, including zero, odd,
// clamped and unknown register writes.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CLK_HALF      = 6;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_PIXELS = 1750;
  localparam int STORE_DEPTH   = fsd_pkg::MAX_WIDTH_DEF;
  localparam int LEVEL_ON      = 127;
  localparam int LEVEL_FULL    = 255;
  localparam int ERR_MAX       = 2047;
  localparam int ERR_MIN       = -2048;

  localparam logic [fsd_pkg::CFG_IDX_W-1:0] REG_UNUSED_LOW = fsd_pkg::CFG_IDX_W'(2);
  localparam logic [fsd_pkg::CFG_IDX_W-1:0] REG_UNUSED_TOP = {fsd_pkg::CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic pixel_on;
    logic last_in_frame;
  } dither_result_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC, RX_LONG} stall_mode_e;
  typedef enum int {LVL_UNIFORM, LVL_THRESHOLD, LVL_EXTREME, LVL_FLAT} level_style_e;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic [fsd_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [fsd_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic [fsd_pkg::GRAY_W-1:0]     gray_i      = '0;
  logic                           out_ready_i = 1'b0;
  logic                           cfg_ready_o;
  logic                           in_ready_o;
  logic                           out_valid_o;
  logic                           pixel_on_o;
  logic                           last_in_frame_o;

  floyd_steinberg_dither u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .gray_i         (gray_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_on_o     (pixel_on_o),
    .last_in_frame_o(last_in_frame_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // predictor state
  logic signed [fsd_pkg::ACC_W-1:0] line_err [STORE_DEPTH];
  int                               carry_right;
  int                               pend_below_right;
  int                               hold_below_left;
  int                               col_pos;
  int                               row_pos;
  logic [fsd_pkg::WIDTH_W-1:0]      cfg_width  = fsd_pkg::WIDTH_RST;
  logic [fsd_pkg::HEIGHT_W-1:0]     cfg_height = fsd_pkg::HEIGHT_RST;

  dither_result_t expected_pixels[$];
  int             error_count = 0;
  int             cycle_count = 0;
  int             burst_left  = 1;
  stall_mode_e    stall_mode  = RX_OPEN;
  int             stall_left  = 0;

  function automatic int clamp_acc(input int v);
    if (v > ERR_MAX) begin
      return ERR_MAX;
    end
    if (v < ERR_MIN) begin
      return ERR_MIN;
    end
    return v;
  endfunction

  function automatic int error_share(input int e, input int k);
    return (e * k) / 16;
  endfunction

  function automatic int active_width();
    if (cfg_width == 0) begin
      return 1;
    end
    if (int'(cfg_width) > STORE_DEPTH) begin
      return STORE_DEPTH;
    end
    return int'(cfg_width);
  endfunction

  task automatic clear_frame();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      line_err[i] = '0;
    end
    carry_right      = 0;
    pend_below_right = 0;
    hold_below_left  = 0;
    col_pos          = 0;
    row_pos          = 0;
  endtask

  task automatic predict_pixel(input logic [fsd_pkg::GRAY_W-1:0] level);
    int w, h, x, y, v, e;
    bit last_col, last_row, on;
    w = active_width();
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    x = col_pos;
    y = row_pos;
    if (x >= w) x = w - 1;
    if (y >= h) y = h - 1;
    last_col = (x == w - 1);
    last_row = (y == h - 1);

    v  = clamp_acc(int'(level) + int'(line_err[x]) + carry_right);
    on = (v >= LEVEL_ON);
    e  = on ? v - LEVEL_FULL : v;

    carry_right = last_col ? 0 : error_share(e, 7);
    if (!last_row) begin
      if (x > 0) begin
        line_err[x-1] = fsd_pkg::ACC_W'(clamp_acc(hold_below_left + error_share(e, 3)));
      end
      hold_below_left  = clamp_acc(pend_below_right + error_share(e, 5));
      pend_below_right = last_col ? 0 : error_share(e, 1);
      if (last_col) begin
        line_err[x]     = fsd_pkg::ACC_W'(hold_below_left);
        hold_below_left = 0;
      end
    end

    expected_pixels.push_back('{pixel_on: on, last_in_frame: last_col && last_row});

    if (last_col) begin
      if (last_row) begin
        clear_frame();
      end else begin
        col_pos = 0;
        row_pos = y + 1;
      end
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
  endtask

  // one pixel transfer, then the burst and gap pattern of the sender
  task automatic send_pixel(input logic [fsd_pkg::GRAY_W-1:0] level);
    int gap;
    in_valid_i <= 1'b1;
    gray_i     <= level;
    do @(posedge clk_i); while (!in_ready_o);
    predict_pixel(level);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                               : $urandom_range(1, 16);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [fsd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fsd_pkg::CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == fsd_pkg::REG_IMAGE_WIDTH) begin
      cfg_width = data[fsd_pkg::WIDTH_W-1:0];
      clear_frame();
    end else if (idx == fsd_pkg::REG_IMAGE_HEIGHT) begin
      cfg_height = data[fsd_pkg::HEIGHT_W-1:0];
      clear_frame();
    end
  endtask

  function automatic logic [fsd_pkg::GRAY_W-1:0] pick_level(input level_style_e style,
                                                            input int base);
    case (style)
      LVL_THRESHOLD: return fsd_pkg::GRAY_W'($urandom_range(112, 142));
      LVL_EXTREME:   return ($urandom_range(0, 1) != 0) ? fsd_pkg::GRAY_W'(LEVEL_FULL) : '0;
      LVL_FLAT:      return fsd_pkg::GRAY_W'(base);
      default:       return fsd_pkg::GRAY_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_default_size();
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd127);
    send_pixel(8'd126);
    send_pixel(8'd128);
    send_pixel(8'd255);
  endtask

  task automatic test_zero_size();
    write_reg(fsd_pkg::REG_IMAGE_WIDTH, '0);
    write_reg(fsd_pkg::REG_IMAGE_HEIGHT, '0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd127);
  endtask

  // unknown indices must leave the frame position alone
  task automatic test_unknown_register();
    write_reg(fsd_pkg::REG_IMAGE_WIDTH, 16'd3);
    write_reg(fsd_pkg::REG_IMAGE_HEIGHT, 16'd2);
    send_pixel(8'd200);
    send_pixel(8'd60);
    write_reg(REG_UNUSED_TOP, '1);
    write_reg(REG_UNUSED_LOW, '0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd130);
    send_pixel(8'd5);
  endtask

  task automatic test_edge_columns();
    write_reg(fsd_pkg::REG_IMAGE_WIDTH, 16'd2);
    write_reg(fsd_pkg::REG_IMAGE_HEIGHT, 16'd3);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd127);
    send_pixel(8'd126);
  endtask

  task automatic test_random_frames(input int budget);
    int           sent, w, h, count, base;
    level_style_e style;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        0: begin
          write_reg(fsd_pkg::REG_IMAGE_WIDTH,
                    fsd_pkg::CFG_DATA_W'($urandom_range(13, 48)));
          write_reg(fsd_pkg::REG_IMAGE_HEIGHT,
                    fsd_pkg::CFG_DATA_W'($urandom_range(1, 4)));
        end
        1: begin
          write_reg(fsd_pkg::REG_IMAGE_WIDTH, fsd_pkg::CFG_DATA_W'($urandom));
          write_reg(fsd_pkg::REG_IMAGE_HEIGHT, fsd_pkg::CFG_DATA_W'($urandom));
        end
        2: write_reg(fsd_pkg::REG_IMAGE_HEIGHT, fsd_pkg::CFG_DATA_W'($urandom_range(1, 8)));
        default: begin
          write_reg(fsd_pkg::REG_IMAGE_WIDTH,
                    fsd_pkg::CFG_DATA_W'($urandom_range(1, 12)));
          write_reg(fsd_pkg::REG_IMAGE_HEIGHT,
                    fsd_pkg::CFG_DATA_W'($urandom_range(1, 6)));
        end
      endcase
      w = active_width();
      h = (cfg_height == 0) ? 1 : int'(cfg_height);
      if (w * h > 400) begin
        count = $urandom_range(5, 60);
      end else begin
        count = $urandom_range(1, 3) * w * h + $urandom_range(0, w);
      end
      if (count > budget - sent) count = budget - sent;
      style = level_style_e'($urandom_range(0, 3));
      base  = $urandom_range(0, 255);
      repeat (count) send_pixel(pick_level(style, base));
      sent += count;
    end
  endtask

  // width register all ones is clamped to the line store depth
  task automatic test_max_width();
    write_reg(fsd_pkg::REG_IMAGE_WIDTH, '1);
    write_reg(fsd_pkg::REG_IMAGE_HEIGHT, 16'd1);
    repeat (40) send_pixel(fsd_pkg::GRAY_W'($urandom_range(0, 255)));
  endtask

  task automatic test_tall_frame();
    write_reg(fsd_pkg::REG_IMAGE_WIDTH, 16'd3);
    write_reg(fsd_pkg::REG_IMAGE_HEIGHT, '1);
    repeat (40) send_pixel(fsd_pkg::GRAY_W'($urandom_range(0, 255)));
  endtask

  // output side: stall pattern with modes of random length
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 4));
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      RX_OPEN:     out_ready_i <= 1'b1;
      RX_LIGHT:    out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:    out_ready_i <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_ready_i <= (stall_left % 3 == 0);
      default:     out_ready_i <= (stall_left % 24 >= 20);
    endcase
  end

  always @(posedge clk_i) begin : check_output
    dither_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("output transfer with nothing expected: pixel_on=%0b last_in_frame=%0b",
               pixel_on_o, last_in_frame_o);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_on_o !== want.pixel_on) begin
          $error("pixel_on mismatch: expected %0b, actual %0b", want.pixel_on, pixel_on_o);
          error_count++;
        end
        if (last_in_frame_o !== want.last_in_frame) begin
          $error("last_in_frame mismatch: expected %0b, actual %0b",
                 want.last_in_frame, last_in_frame_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clear_frame();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_size();
    test_zero_size();
    test_unknown_register();
    test_edge_columns();
    test_random_frames(RANDOM_PIXELS);
    test_max_width();
    test_tall_frame();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/fsd_pkg.sv
src/floyd_steinberg_dither.sv
bench/testbench.sv
